FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the NMS checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CNMS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cnms: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CNMS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cnms: next-cycle check failed");

`endif

FILE: rtl/cnms_pkg.sv
// ----------------------------------------------------------------------------
// cnms_pkg
// Types, constants and the angle binning function for Canny NMS.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cnms_pkg;

    localparam int MAG_W      = 8;
    localparam int ANG_W      = 10;
    localparam int POS_W      = 10;
    localparam int CFG_W      = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int SIZE_EXT_W = 13;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_IMG_SIZE   = 1024;
    localparam int MIN_IMG_SIZE   = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    typedef logic [MAG_W-1:0] mag_t;
    typedef logic [ANG_W-1:0] ang_t;

    typedef enum logic [1:0] {
        DIR_HORZ = 2'd0,
        DIR_DIAG = 2'd1,
        DIR_VERT = 2'd2,
        DIR_ANTI = 2'd3
    } dir_t;

    // one line-memory word: magnitude two rows up, one row up, angle one row up
    typedef struct packed {
        mag_t older;
        mag_t prior;
        ang_t angle;
    } line_entry_t;

    // Fold (a > 360 -> a - 720) and bin edges at 45/135/225/315 half degrees,
    // expressed directly on the raw 10-bit code.
    function automatic dir_t angle_bin(input ang_t a);
        dir_t d;
        if (a inside {[10'd0:10'd45], [10'd316:10'd405], [10'd676:10'd765]})
            d = DIR_HORZ;
        else if (a inside {[10'd226:10'd315], [10'd586:10'd675], [10'd946:10'd1023]})
            d = DIR_DIAG;
        else if (a inside {[10'd136:10'd225], [10'd496:10'd585], [10'd856:10'd945]})
            d = DIR_VERT;
        else
            d = DIR_ANTI;
        return d;
    endfunction

endpackage

FILE: rtl/canny_non_maximum_suppression.sv
// ----------------------------------------------------------------------------
// canny_non_maximum_suppression: 3x3 non-maximum suppression on a pixel stream
// A result passes stage 1 and the output register after the beat of the pixel that
// closes its window (one row down, one column right). Throughput: one pixel per
// cycle unless out_ready stalls; memory: one read (at accept), one write (later).
// Reset: counters, window and config (1024 x 1024) clear; line memory does not.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module canny_non_maximum_suppression #(
    parameter int MAX_WIDTH  = cnms_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = cnms_pkg::DEF_MAX_HEIGHT
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_write,
    input  logic [cnms_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cnms_pkg::CFG_W-1:0]    cfg_data,

    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [cnms_pkg::MAG_W-1:0]    magnitude,
    input  logic [cnms_pkg::ANG_W-1:0]    angle_half_deg,
    input  logic                          frame_start,

    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [cnms_pkg::MAG_W-1:0]    suppressed_value,
    output logic [cnms_pkg::POS_W-1:0]    out_row,
    output logic [cnms_pkg::POS_W-1:0]    out_col,
    output logic                          frame_done
);

    import cnms_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int W_RST = (DEF_IMG_SIZE < MAX_WIDTH)  ? DEF_IMG_SIZE : MAX_WIDTH;
    localparam int H_RST = (DEF_IMG_SIZE < MAX_HEIGHT) ? DEF_IMG_SIZE : MAX_HEIGHT;
    localparam logic [CW-1:0] W_LAST_RST = CW'(W_RST - 1);
    localparam logic [RW-1:0] H_LAST_RST = RW'(H_RST - 1);

    // config, kept as clamped last column / last row
    logic [CW-1:0] w_last_reg;
    logic [RW-1:0] h_last_reg;
    logic [SIZE_EXT_W-1:0] cfg_ext;
    logic [CW-1:0] w_last_next;
    logic [RW-1:0] h_last_next;

    // position counters
    logic [CW-1:0] col_reg, col_cur, col_next;
    logic [RW-1:0] row_reg, row_cur, row_next;
    logic          col_wrap;

    // stage 1: accepted pixel waiting for its line-memory word
    logic             s1_valid_reg;
    logic [CW-1:0]    s1_col_reg;
    mag_t             s1_mag_reg;
    ang_t             s1_ang_reg;
    logic             s1_emit_reg;
    logic             s1_inner_reg;
    logic             s1_done_reg;
    logic [POS_W-1:0] s1_row_out_reg;
    logic [POS_W-1:0] s1_col_out_reg;
    logic             s1_adv;
    logic             in_accept;

    // line memory and write-to-read bypass
    line_entry_t line_mem [MAX_WIDTH];
    line_entry_t mem_q_reg;
    line_entry_t fwd_data_reg;
    logic        fwd_reg;
    line_entry_t entry;
    line_entry_t wr_data;
    logic        wr_en;

    // window: column 1 (left) and column 2 (centre), index 0 up .. 2 down
    mag_t win1_reg [3];
    mag_t win2_reg [3];
    dir_t centre_bin_reg;
    mag_t new_col [3];
    mag_t nb_a, nb_b, ctr, res;

    // output register
    logic             out_valid_reg, out_valid_next;
    mag_t             out_value_reg;
    logic [POS_W-1:0] out_row_reg;
    logic [POS_W-1:0] out_col_reg;
    logic             out_done_reg;

    // ---------------- config ----------------
    always_comb
    begin
        cfg_ext = SIZE_EXT_W'(cfg_data);
        if (cfg_ext < SIZE_EXT_W'(MIN_IMG_SIZE))
        begin
            w_last_next = CW'(MIN_IMG_SIZE - 1);
            h_last_next = RW'(MIN_IMG_SIZE - 1);
        end
        else
        begin
            if (cfg_ext > SIZE_EXT_W'(MAX_WIDTH))
                w_last_next = CW'(MAX_WIDTH - 1);
            else
                w_last_next = CW'(cfg_ext - SIZE_EXT_W'(1));
            if (cfg_ext > SIZE_EXT_W'(MAX_HEIGHT))
                h_last_next = RW'(MAX_HEIGHT - 1);
            else
                h_last_next = RW'(cfg_ext - SIZE_EXT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_last_reg <= W_LAST_RST;
            h_last_reg <= H_LAST_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:  w_last_reg <= w_last_next;
                CFG_IMAGE_HEIGHT: h_last_reg <= h_last_next;
                default:          ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    assign s1_adv    = !out_valid_reg || out_ready;
    assign in_ready  = !s1_valid_reg || s1_adv;
    assign in_accept = in_valid && in_ready;
    assign wr_en     = s1_valid_reg && s1_adv;

    // ---------------- counters ----------------
    always_comb
    begin
        col_cur  = frame_start ? '0 : col_reg;
        row_cur  = frame_start ? '0 : row_reg;
        col_wrap = (col_cur >= w_last_reg);
        col_next = col_wrap ? '0 : col_cur + CW'(1);
        if (!col_wrap)
            row_next = row_cur;
        else if (row_cur >= h_last_reg)
            row_next = '0;
        else
            row_next = row_cur + RW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
                // same column written this edge: memory read sees stale data
                fwd_reg <= wr_en && (s1_col_reg == col_cur);
            end
            if (in_accept)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_col_reg     <= col_cur;
            s1_mag_reg     <= magnitude;
            s1_ang_reg     <= angle_half_deg;
            s1_emit_reg    <= (row_cur != '0) && (col_cur != '0) &&
                              (row_cur <= h_last_reg) && (col_cur <= w_last_reg);
            s1_inner_reg   <= (row_cur > RW'(1)) && (col_cur > CW'(1));
            s1_done_reg    <= (row_cur == h_last_reg) && (col_cur == w_last_reg);
            s1_row_out_reg <= POS_W'(row_cur - RW'(1));
            s1_col_out_reg <= POS_W'(col_cur - CW'(1));
            fwd_data_reg   <= wr_data;
        end
    end

    // ---------------- line memory ----------------
    always_ff @(posedge clk)
    begin
        if (wr_en)
            line_mem[s1_col_reg] <= wr_data;
        if (in_accept)
            mem_q_reg <= line_mem[col_cur];
    end

    // ---------------- window and decision ----------------
    always_comb
    begin
        entry         = fwd_reg ? fwd_data_reg : mem_q_reg;
        wr_data.older = entry.prior;
        wr_data.prior = s1_mag_reg;
        wr_data.angle = s1_ang_reg;
        new_col[0]    = entry.older;
        new_col[1]    = entry.prior;
        new_col[2]    = s1_mag_reg;
        ctr           = win2_reg[1];
        // after the shift: left = win1, centre = win2, right = new_col
        case (centre_bin_reg)
            DIR_HORZ:
            begin
                nb_a = win1_reg[1];
                nb_b = new_col[1];
            end
            DIR_DIAG:
            begin
                nb_a = win1_reg[0];
                nb_b = new_col[2];
            end
            DIR_VERT:
            begin
                nb_a = win2_reg[0];
                nb_b = win2_reg[2];
            end
            default:
            begin
                nb_a = win1_reg[2];
                nb_b = new_col[0];
            end
        endcase
        res = (s1_inner_reg && (ctr > nb_a) && (ctr > nb_b)) ? ctr : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                win1_reg[k] <= '0;
                win2_reg[k] <= '0;
            end
            centre_bin_reg <= DIR_HORZ;
        end
        else if (wr_en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                win1_reg[k] <= win2_reg[k];
                win2_reg[k] <= new_col[k];
            end
            centre_bin_reg <= angle_bin(entry.angle);
        end
    end

    // ---------------- output register ----------------
    always_comb
    begin
        if (wr_en && s1_emit_reg)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && s1_emit_reg)
        begin
            out_value_reg <= res;
            out_row_reg   <= s1_row_out_reg;
            out_col_reg   <= s1_col_out_reg;
            out_done_reg  <= s1_done_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign suppressed_value = out_value_reg;
    assign out_row          = out_row_reg;
    assign out_col          = out_col_reg;
    assign frame_done       = out_done_reg;

endmodule

FILE: rtl/cnms_checker.sv
// ----------------------------------------------------------------------------
// cnms_checker
// Port-level checks for the NMS block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cnms_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [cnms_pkg::MAG_W-1:0]     suppressed_value,
    input  logic [cnms_pkg::POS_W-1:0]     out_row,
    input  logic [cnms_pkg::POS_W-1:0]     out_col,
    input  logic                           frame_done
);

    import cnms_pkg::*;

    logic out_stall;
    logic out_beat;
    logic in_beat;

    assign out_stall = out_valid && !out_ready;
    assign out_beat  = out_valid && out_ready;
    assign in_beat   = in_valid && in_ready;

    // stalled result holds
    `CNMS_ASSERT_NXT(a_out_hold, clk, rst_n, out_stall,
        out_valid && $stable(suppressed_value) && $stable(out_row) &&
        $stable(out_col) && $stable(frame_done))

    // input side only stops while the result register is blocked
    `CNMS_ASSERT_IMP(a_ready_stall, clk, rst_n, !in_ready, out_stall)

    // a fresh result always comes from an accepted beat that passed through stage 1
    `CNMS_ASSERT_IMP(a_out_source, clk, rst_n, $rose(out_valid), $past(in_beat, 2))

    // the next frame's first result needs a full row of pixels first
    `CNMS_ASSERT_NXT(a_frame_gap, clk, rst_n, out_beat && frame_done, !out_valid)

endmodule

bind canny_non_maximum_suppression cnms_checker u_cnms_checker (.*);

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: canny_non_maximum_suppression
// Streams gradient pixel frames through the NMS block under varying sizes
// and handshake pressure. A local line-buffer predictor computes every
// emitted centre pixel; results are checked in order, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    import cnms_pkg::*;

    typedef struct {
        mag_t             value;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             done;
    } nms_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    mag_t                 magnitude;
    ang_t                 angle_half_deg;
    logic                 frame_start;
    logic                 out_valid;
    logic                 out_ready;
    mag_t                 suppressed_value;
    logic [POS_W-1:0]     out_row;
    logic [POS_W-1:0]     out_col;
    logic                 frame_done;

    int                   idle_pct = 0;
    int                   stall_pct = 0;
    int                   mismatch_count = 0;
    nms_result_t          centre_queue[$];

    // predictor state
    mag_t                 line_old [DEF_MAX_WIDTH];
    mag_t                 line_prev [DEF_MAX_WIDTH];
    ang_t                 line_ang [DEF_MAX_WIDTH];
    mag_t                 win [3][3];
    ang_t                 held_angle;
    int unsigned          pix_col;
    int unsigned          pix_row;
    logic [CFG_W-1:0]     width_reg;
    logic [CFG_W-1:0]     height_reg;

    canny_non_maximum_suppression u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .magnitude        (magnitude),
        .angle_half_deg   (angle_half_deg),
        .frame_start      (frame_start),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .suppressed_value (suppressed_value),
        .out_row          (out_row),
        .out_col          (out_col),
        .frame_done       (frame_done)
    );

    always #4 clk = ~clk;

    function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v);
        if (v < MIN_IMG_SIZE)
            return MIN_IMG_SIZE;
        if (v > DEF_MAX_WIDTH)
            return DEF_MAX_WIDTH;
        return v;
    endfunction

    // fold to (-180,180] deg, then four 45-deg-wide bins around each axis
    function automatic dir_t gradient_dir(input ang_t code);
        int a;
        a = int'(code);
        if (a > 360)
            a -= 720;
        if ((a > -45 && a <= 45) || a > 315 || a <= -315)
            return DIR_HORZ;
        if ((a > -135 && a <= -45) || (a > 225 && a <= 315))
            return DIR_DIAG;
        if ((a > -225 && a <= -135) || (a > 135 && a <= 225))
            return DIR_VERT;
        return DIR_ANTI;
    endfunction

    function automatic void model_reset();
        for (int i = 0; i < DEF_MAX_WIDTH; i++)
        begin
            line_old[i]  = '0;
            line_prev[i] = '0;
            line_ang[i]  = '0;
        end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                win[i][j] = '0;
        held_angle = '0;
        pix_col    = 0;
        pix_row    = 0;
        width_reg  = CFG_W'(DEF_IMG_SIZE);
        height_reg = CFG_W'(DEF_IMG_SIZE);
    endfunction

    // one accepted pixel; queues the centre one row up, one column left
    function automatic void nms_model_step(input mag_t mag, input ang_t ang,
                                           input logic fs);
        int unsigned w;
        int unsigned h;
        int unsigned r;
        int unsigned c;
        mag_t        up;
        mag_t        mid;
        mag_t        ctr;
        mag_t        nb_a;
        mag_t        nb_b;
        mag_t        res;
        ang_t        nxt;
        nms_result_t item;
        w = clamp_dim(width_reg);
        h = clamp_dim(height_reg);
        if (fs)
        begin
            pix_col = 0;
            pix_row = 0;
        end
        r = pix_row;
        c = pix_col;
        up  = line_old[c];
        mid = line_prev[c];
        nxt = line_ang[c];
        line_old[c]  = mid;
        line_prev[c] = mag;
        line_ang[c]  = ang;
        for (int k = 0; k < 3; k++)
        begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
        end
        win[0][2] = up;
        win[1][2] = mid;
        win[2][2] = mag;
        if (r >= 1 && c >= 1 && r < h && c < w)
        begin
            res = '0;
            if (r >= 2 && c >= 2)
            begin
                case (gradient_dir(held_angle))
                    DIR_HORZ:
                    begin
                        nb_a = win[1][0];
                        nb_b = win[1][2];
                    end
                    DIR_DIAG:
                    begin
                        nb_a = win[0][0];
                        nb_b = win[2][2];
                    end
                    DIR_VERT:
                    begin
                        nb_a = win[0][1];
                        nb_b = win[2][1];
                    end
                    default:
                    begin
                        nb_a = win[2][0];
                        nb_b = win[0][2];
                    end
                endcase
                ctr = win[1][1];
                if (ctr > nb_a && ctr > nb_b)
                    res = ctr;
            end
            item.value = res;
            item.row   = POS_W'(r - 1);
            item.col   = POS_W'(c - 1);
            item.done  = (r == h - 1 && c == w - 1);
            centre_queue.push_back(item);
        end
        held_angle = nxt;
        c++;
        if (c >= w)
        begin
            c = 0;
            r++;
            if (r >= h)
                r = 0;
        end
        pix_col = c;
        pix_row = r;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 100)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    always @(posedge clk)
    begin : check_results
        nms_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (centre_queue.size() == 0)
                report_mismatch($sformatf("unexpected beat at row %0d col %0d",
                                          out_row, out_col));
            else
            begin
                want = centre_queue.pop_front();
                if (suppressed_value !== want.value)
                    report_mismatch($sformatf("(%0d,%0d) value %0d, want %0d", want.row,
                                              want.col, suppressed_value, want.value));
                if (out_row !== want.row)
                    report_mismatch($sformatf("row %0d, want %0d", out_row, want.row));
                if (out_col !== want.col)
                    report_mismatch($sformatf("col %0d, want %0d", out_col, want.col));
                if (frame_done !== want.done)
                    report_mismatch($sformatf("(%0d,%0d) frame_done %0b, want %0b",
                                              want.row, want.col, frame_done, want.done));
            end
        end
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic send_pixel(input mag_t mag, input ang_t ang, input logic fs);
        if ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        in_valid       <= 1'b1;
        magnitude      <= mag;
        angle_half_deg <= ang;
        frame_start    <= fs;
        do
            @(posedge clk);
        while (!in_ready);
        nms_model_step(mag, ang, fs);
    endtask

    // random content; some low-range magnitudes for ties, some angles on bin edges
    task automatic send_frame(input int unsigned n_pix, input bit with_start);
        mag_t mag;
        ang_t ang;
        for (int unsigned i = 0; i < n_pix; i++)
        begin
            if ($urandom_range(3) == 0)
                mag = mag_t'($urandom_range(3));
            else
                mag = mag_t'($urandom_range(255));
            if ($urandom_range(4) == 0)
                ang = ang_t'(45 + 90 * $urandom_range(10) + $urandom_range(1));
            else
                ang = ang_t'($urandom_range(1023));
            send_pixel(mag, ang, with_start && i == 0);
        end
    endtask

    // drain until every queued result has been seen, then idle with in_valid low
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (centre_queue.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        cfg_write <= 1'b1;
        cfg_index <= CFG_IMAGE_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        cfg_index <= CFG_IMAGE_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        width_reg  = w;
        height_reg = h;
    endtask

    // 5x5 frame: inner centres hit every bin, the wrap and out-of-range codes
    task automatic test_directed_window();
        mag_t mags [25] = '{10, 0, 255, 20, 30,
                            40, 200, 200, 90, 5,
                            60, 100, 255, 80, 7,
                            254, 50, 200, 255, 1,
                            3, 128, 129, 0, 255};
        ang_t angs [25] = '{0, 719, 720, 1023, 360,
                            405, 45, 46, 136, 406,
                            495, 226, 316, 361, 585,
                            586, 1023, 675, 676, 765,
                            766, 945, 946, 135, 225};
        idle_pct  = 0;
        stall_pct = 0;
        wait_idle();
        set_size(5, 5);
        for (int i = 0; i < 25; i++)
            send_pixel(mags[i], angs[i], i == 0);
    endtask

    // sizes outside [3,1024] are clamped to the nearest limit
    task automatic test_size_clamp();
        idle_pct  = 13;
        stall_pct = 13;
        wait_idle();
        set_size(0, 2047);
        send_frame(3 * 6, 1);
        wait_idle();
        // a full row plus a few pixels: the row has to wrap at 1024
        set_size(2047, 1);
        send_frame(1024 + 5, 1);
        wait_idle();
        set_size(1, 2);
        send_frame(9, 1);
        // no frame_start: counters wrap into the next frame
        send_frame(9, 0);
        send_frame(9, 0);
    endtask

    // shrink width, then height, while the counters sit beyond the new size
    task automatic test_shrink_midframe();
        idle_pct  = 0;
        stall_pct = 61;
        wait_idle();
        set_size(12, 10);
        send_frame(5 * 12 + 7, 1);
        wait_idle();
        set_size(4, 10);
        send_frame(9, 0);
        wait_idle();
        set_size(4, 3);
        send_frame(16, 0);
    endtask

    // a new size is always followed by frame_start, so no stale line entry is read
    task automatic test_random_frames(input int idle, input int stall,
                                      input int unsigned n_items);
        int unsigned      sent;
        int unsigned      whole;
        int unsigned      n;
        int unsigned      frames;
        int unsigned      kind;
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] h;
        bit               complete;
        idle_pct  = idle;
        stall_pct = stall;
        sent = 0;
        while (sent < n_items)
        begin
            wait_idle();
            case ($urandom_range(19))
                0:       w = CFG_W'($urandom_range(2));
                1:       w = CFG_W'($urandom_range(64, 17));
                default: w = CFG_W'($urandom_range(16, 3));
            endcase
            case ($urandom_range(19))
                0:       h = CFG_W'($urandom_range(2));
                1:       h = CFG_W'($urandom_range(24, 13));
                default: h = CFG_W'($urandom_range(12, 3));
            endcase
            set_size(w, h);
            whole    = clamp_dim(w) * clamp_dim(h);
            complete = 0;
            frames   = $urandom_range(4, 1);
            repeat (frames)
            begin
                kind = $urandom_range(9);
                if (kind < 2 && complete)
                    n = whole;
                else if (kind < 8)
                    n = whole;
                else
                    n = $urandom_range(whole - 1, 1);
                // keep the phase near its item budget
                if (n > n_items - sent)
                    n = n_items - sent;
                send_frame(n, !(kind < 2 && complete));
                complete = (n == whole);
                sent += n;
            end
        end
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        cfg_write      <= 1'b0;
        cfg_index      <= CFG_IMAGE_WIDTH;
        cfg_data       <= '0;
        in_valid       <= 1'b0;
        magnitude      <= '0;
        angle_half_deg <= '0;
        frame_start    <= 1'b0;
        out_ready      <= 1'b0;
        model_reset();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_window();
        test_size_clamp();
        test_shrink_midframe();
        test_random_frames(0, 0, 90);
        test_random_frames(61, 0, 90);
        test_random_frames(0, 61, 90);
        test_random_frames(13, 13, 90);

        wait_idle();
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
